/* rtl/flt_pkg.sv */
// ============================================================================
// flt_pkg
// Shared types, codes, sizes and fixed-point helpers for the Finito trainer.
// ============================================================================
package flt_pkg;

    localparam int FLT_NUM_SAMPLES     = 1024;
    localparam int FLT_DIM             = 64;
    localparam int FLT_SIGMOID_ENTRIES = 1024;

    localparam int ACTION_W  = 2;
    localparam int SAMPLE_W  = 10;
    localparam int FEATURE_W = 6;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Width used for exact intermediate sums before saturation.
    localparam int WIDE_W = 80;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_FEATURE = 2'd0,
        ACT_LOAD_LABEL   = 2'd1,
        ACT_STEP         = 2'd2,
        ACT_READ_MEAN    = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE  = 2'd0,
        CFG_REG_WEIGHT = 2'd1,
        CFG_INV_COUNT  = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    localparam logic RK_STEP = 1'b0;
    localparam logic RK_MEAN = 1'b1;

    localparam logic [30:0] STEP_SIZE_RESET  = 31'd167772;
    localparam logic [30:0] REG_WEIGHT_RESET = 31'd0;
    localparam logic [31:0] INV_COUNT_RESET  = 32'd4194304;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat_t;

    // Status of the update pipeline as seen by the sequencer.
    typedef struct packed {
        logic we;
        logic sat;
        logic busy;
    } upd_stat_t;

    localparam wide_t SAT_MAX = 80'sd2147483647;
    localparam wide_t SAT_MIN = -80'sd2147483648;

    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        if (v > SAT_MAX) begin
            r.val = 32'sh7FFFFFFF;
            r.sat = 1'b1;
        end
        else if (v < SAT_MIN) begin
            r.val = 32'sh80000000;
            r.sat = 1'b1;
        end
        else begin
            r.val = 32'(v);
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Round half up at bit position sh, then saturate to a word.
    function automatic sat_t rnd_sat(input wide_t p, input int unsigned sh);
        wide_t q;
        q = (p + (80'sd1 <<< (sh - 1))) >>> sh;
        return sat32(q);
    endfunction

endpackage

/* rtl/flt_ram.sv */
// ============================================================================
// flt_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
module flt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/flt_sig_rom.sv */
// ============================================================================
// flt_sig_rom
// Constant table of -1/(1+exp(t)) over t in [-8, 8), Q8.24, registered read.
// ============================================================================
module flt_sig_rom #(
    parameter int Entries = 1024
) (
    input  logic                       clk,
    input  logic [$clog2(Entries)-1:0] addr,
    output logic signed [31:0]         data
);

    typedef logic signed [31:0] rom_t [Entries];

    localparam logic [63:0] Q62_ONE = 64'd1 << 62;

    function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Unsigned restoring division, only ever evaluated while the table is built.
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a) in Q2.62 for an unsigned Q8.24 argument of at most 8.
    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0] r;
        logic [63:0] h;
        r = a << 30;
        h = Q62_ONE - udiv(r, 64'd5);
        h = Q62_ONE - (mul62(r, h) >> 2);
        h = Q62_ONE - udiv(mul62(r, h), 64'd3);
        h = Q62_ONE - (mul62(r, h) >> 1);
        h = Q62_ONE - mul62(r, h);
        for (int k = 0; k < 8; k++)
        begin
            h = mul62(h, h);
        end
        return h;
    endfunction

    function automatic rom_t build_table();
        rom_t        tab;
        longint      t;
        logic [63:0] mag;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] n32;
        logic [63:0] d32;
        logic [63:0] val;
        for (int i = 0; i < Entries; i++)
        begin
            t   = -(64'sd1 <<< 27)
                  + longint'(udiv(64'(2 * i + 1) << 27, 64'(Entries)));
            mag = (t < 0) ? 64'(-t) : 64'(t);
            e   = exp_neg(mag);
            num = (t >= 0) ? e : Q62_ONE;
            n32 = num >> 30;
            d32 = (Q62_ONE + e) >> 30;
            val = udiv((n32 << 24) + (d32 >> 1), d32);
            tab[i] = -signed'(32'(val));
        end
        return tab;
    endfunction

    localparam rom_t SIG_TABLE = build_table();

    logic signed [31:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SIG_TABLE[addr];
    end

    assign data = data_reg;

endmodule

/* rtl/flt_update.sv */
// ============================================================================
// flt_update
// Nine-stage per-column update: forms delta, the new stored vector element
// and the new mean element, and flags any saturation on the way.
// ============================================================================
module flt_update #(
    parameter int ZA_W = 16,
    parameter int MA_W = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [ZA_W-1:0]        in_zaddr,
    input  logic [MA_W-1:0]        in_maddr,
    input  logic signed [31:0]     x,
    input  logic signed [31:0]     z,
    input  logic signed [31:0]     m,
    input  logic signed [31:0]     gy,
    input  logic [30:0]            step_size,
    input  logic [30:0]            reg_weight,
    input  logic [31:0]            inv_count,
    output logic [ZA_W-1:0]        out_zaddr,
    output logic [MA_W-1:0]        out_maddr,
    output logic signed [31:0]     out_z,
    output logic signed [31:0]     out_m,
    output flt_pkg::upd_stat_t     stat
);
    import flt_pkg::*;

    localparam int NST = 9;

    logic            v_reg  [NST];
    logic            s_reg  [NST];
    logic [ZA_W-1:0] za_reg [NST];
    logic [MA_W-1:0] ma_reg [NST];
    logic signed [31:0] m_reg [NST];
    logic signed [31:0] z_reg [NST];
    logic signed [31:0] d_reg [NST];

    logic signed [63:0] p1a_reg;
    logic signed [63:0] p1b_reg;
    logic signed [31:0] t1_reg;
    logic signed [31:0] t2_reg;
    logic signed [31:0] grad_reg;
    logic signed [63:0] pst_reg;
    logic signed [31:0] step_reg;
    logic signed [31:0] delta_reg;
    logic signed [65:0] pinc_reg;
    logic signed [31:0] znew_reg;
    logic signed [31:0] inc_reg;
    logic signed [31:0] mnew_reg;

    sat_t d_c;
    sat_t t1_c;
    sat_t t2_c;
    sat_t grad_c;
    sat_t step_c;
    sat_t delta_c;
    sat_t znew_c;
    sat_t inc_c;
    sat_t mnew_c;

    always_comb
    begin
        d_c     = sat32(WIDE_W'(m) - WIDE_W'(z));
        t1_c    = rnd_sat(WIDE_W'(p1a_reg), 24);
        t2_c    = rnd_sat(WIDE_W'(p1b_reg), 24);
        grad_c  = sat32(WIDE_W'(t1_reg) + WIDE_W'(t2_reg));
        step_c  = rnd_sat(WIDE_W'(pst_reg), 24);
        delta_c = sat32(WIDE_W'(d_reg[4]) - WIDE_W'(step_reg));
        znew_c  = sat32(WIDE_W'(z_reg[5]) + WIDE_W'(delta_reg));
        inc_c   = rnd_sat(WIDE_W'(pinc_reg), 32);
        mnew_c  = sat32(WIDE_W'(m_reg[7]) + WIDE_W'(inc_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        za_reg[0] <= in_zaddr;
        ma_reg[0] <= in_maddr;
        m_reg[0]  <= m;
        z_reg[0]  <= z;
        d_reg[0]  <= d_c.val;
        s_reg[0]  <= d_c.sat;
        for (int i = 1; i < NST; i++)
        begin
            za_reg[i] <= za_reg[i-1];
            ma_reg[i] <= ma_reg[i-1];
            m_reg[i]  <= m_reg[i-1];
            z_reg[i]  <= z_reg[i-1];
            d_reg[i]  <= d_reg[i-1];
        end

        p1a_reg <= 64'(gy) * 64'(x);
        p1b_reg <= 64'(signed'({1'b0, reg_weight})) * 64'(m);

        t1_reg   <= t1_c.val;
        t2_reg   <= t2_c.val;
        s_reg[1] <= s_reg[0] | t1_c.sat | t2_c.sat;

        grad_reg <= grad_c.val;
        s_reg[2] <= s_reg[1] | grad_c.sat;

        pst_reg  <= 64'(signed'({1'b0, step_size})) * 64'(grad_reg);
        s_reg[3] <= s_reg[2];

        step_reg <= step_c.val;
        s_reg[4] <= s_reg[3] | step_c.sat;

        delta_reg <= delta_c.val;
        s_reg[5]  <= s_reg[4] | delta_c.sat;

        pinc_reg <= 66'(delta_reg) * 66'(signed'({1'b0, inv_count}));
        znew_reg <= znew_c.val;
        s_reg[6] <= s_reg[5] | znew_c.sat;

        inc_reg  <= inc_c.val;
        s_reg[7] <= s_reg[6] | inc_c.sat;

        mnew_reg <= mnew_c.val;
        s_reg[8] <= s_reg[7] | mnew_c.sat;
    end

    // The new z rides along from stage seven to the final stage.
    logic signed [31:0] zout_reg [2];

    always_ff @(posedge clk)
    begin
        zout_reg[0] <= znew_reg;
        zout_reg[1] <= zout_reg[0];
    end

    logic any_valid;

    always_comb
    begin
        any_valid = 1'b0;
        for (int i = 0; i < NST; i++)
        begin
            any_valid = any_valid | v_reg[i];
        end
    end

    assign out_zaddr = za_reg[NST-1];
    assign out_maddr = ma_reg[NST-1];
    assign out_z     = zout_reg[1];
    assign out_m     = mnew_reg;
    assign stat.we   = v_reg[NST-1];
    assign stat.sat  = v_reg[NST-1] & s_reg[NST-1];
    assign stat.busy = any_valid;

endmodule

/* rtl/finito_logistic_trainer.sv */
// ============================================================================
// finito_logistic_trainer
// Finito incremental-gradient trainer for L2-regularized logistic regression.
// ============================================================================
// Loads give no word and leave the block idle. A mean read passes through a
// single busy read state, which registers its word.
// A train step stays busy until it gives its word: one read pass over the
// feature and mean memories for the dot product, a short scalar chain, and one
// pass through the nine-stage update pipeline, each pass one column per cycle,
// plus the drains. A step on a sample out of range gives no word. After
// reset the block is busy while it clears the stored vectors and the mean.
// Result words cannot be stalled.
module finito_logistic_trainer #(
    parameter int NUM_SAMPLES     = flt_pkg::FLT_NUM_SAMPLES,
    parameter int DIM             = flt_pkg::FLT_DIM,
    parameter int SIGMOID_ENTRIES = flt_pkg::FLT_SIGMOID_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [flt_pkg::ACTION_W-1:0]    action,
    input  logic [flt_pkg::SAMPLE_W-1:0]    sample,
    input  logic [flt_pkg::FEATURE_W-1:0]   feature,
    input  logic signed [31:0]              value,
    output logic                            done,
    output logic                            result_kind,
    output logic signed [31:0]              result_value,
    output logic                            saturated,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [flt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);
    import flt_pkg::*;

    localparam int ZDEPTH = NUM_SAMPLES * DIM;
    localparam int ZA_W   = $clog2(ZDEPTH);
    localparam int LA_W   = $clog2(NUM_SAMPLES);
    localparam int MA_W   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int IW     = $clog2(SIGMOID_ENTRIES);
    localparam int ACC_W  = 64 + MA_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DOT,
        ST_DOT_WAIT,
        ST_ROUND,
        ST_UPROD,
        ST_INDEX,
        ST_GPROD,
        ST_GY,
        ST_UPD,
        ST_UPD_WAIT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. The port never pushes back; unknown
    // indexes are dropped.
    // ------------------------------------------------------------------
    logic [30:0] step_size_reg;
    logic [30:0] reg_weight_reg;
    logic [31:0] inv_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= STEP_SIZE_RESET;
            reg_weight_reg <= REG_WEIGHT_RESET;
            inv_count_reg  <= INV_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data[30:0];
                CFG_REG_WEIGHT: reg_weight_reg <= cfg_data[30:0];
                CFG_INV_COUNT:  inv_count_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state and result registers.
    // ------------------------------------------------------------------
    state_t          state_reg;
    logic [ZA_W-1:0] clr_cnt_reg;
    logic [MA_W-1:0] cnt_reg;
    logic [ZA_W-1:0] base_reg;
    logic            rd_ok_reg;
    logic            sat_reg;
    logic            dv1_reg;
    logic            dv2_reg;
    logic            issue_d_reg;
    logic [ZA_W-1:0] za_d_reg;
    logic [MA_W-1:0] ma_d_reg;
    logic            done_reg;
    logic            kind_reg;
    logic signed [31:0] value_reg;
    logic            satout_reg;

    // Datapath registers of the dot product and the scalar chain.
    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      dot_reg;
    logic signed [63:0]      uprod_reg;
    logic signed [63:0]      gprod_reg;
    logic signed [31:0]      gy_reg;

    logic accept;
    logic step_ok;
    logic col_ok;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign step_ok = (32'(sample) < 32'(NUM_SAMPLES));
    assign col_ok  = (32'(feature) < 32'(DIM));

    // ------------------------------------------------------------------
    // Memories.
    // ------------------------------------------------------------------
    logic            feat_we;
    logic [ZA_W-1:0] feat_waddr;
    logic            pass_re;
    logic [ZA_W-1:0] pass_zaddr;
    logic signed [31:0] feat_rdata;

    logic            label_we;
    logic            label_re;
    logic [LA_W-1:0] label_addr;
    logic signed [31:0] label_rdata;

    logic            z_we;
    logic [ZA_W-1:0] z_waddr;
    logic [31:0]     z_wdata;
    logic signed [31:0] z_rdata;

    logic            mean_we;
    logic [MA_W-1:0] mean_waddr;
    logic [31:0]     mean_wdata;
    logic            mean_re;
    logic [MA_W-1:0] mean_raddr;
    logic signed [31:0] mean_rdata;

    logic [ZA_W-1:0]    upd_zaddr;
    logic [MA_W-1:0]    upd_maddr;
    logic signed [31:0] upd_z;
    logic signed [31:0] upd_m;
    upd_stat_t          upd_stat;

    logic               clearing;

    assign clearing = (state_reg == ST_CLEAR);

    always_comb
    begin
        feat_we    = accept && (action_t'(action) == ACT_LOAD_FEATURE) && step_ok && col_ok;
        feat_waddr = ZA_W'(32'(sample) * 32'(DIM) + 32'(feature));
        pass_re    = (state_reg == ST_DOT) || (state_reg == ST_UPD);
        pass_zaddr = base_reg + ZA_W'(cnt_reg);

        label_we   = accept && (action_t'(action) == ACT_LOAD_LABEL) && step_ok;
        label_re   = accept && (action_t'(action) == ACT_STEP) && step_ok;
        label_addr = LA_W'(sample);

        // The clearing pass owns the write ports of z and mean after reset.
        z_we    = clearing ? 1'b1 : upd_stat.we;
        z_waddr = clearing ? clr_cnt_reg : upd_zaddr;
        z_wdata = clearing ? 32'd0 : upd_z;

        mean_we    = clearing ? (clr_cnt_reg < ZA_W'(DIM)) : upd_stat.we;
        mean_waddr = clearing ? MA_W'(clr_cnt_reg) : upd_maddr;
        mean_wdata = clearing ? 32'd0 : upd_m;
        mean_re    = pass_re || (accept && (action_t'(action) == ACT_READ_MEAN));
        mean_raddr = (state_reg == ST_IDLE) ? MA_W'(feature) : cnt_reg;
    end

    flt_ram #(.WIDTH(32), .DEPTH(ZDEPTH)) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (value),
        .re    (pass_re),
        .raddr (pass_zaddr),
        .rdata (feat_rdata)
    );

    flt_ram #(.WIDTH(32), .DEPTH(NUM_SAMPLES)) u_label_ram (
        .clk   (clk),
        .we    (label_we),
        .waddr (label_addr),
        .wdata (value),
        .re    (label_re),
        .raddr (label_addr),
        .rdata (label_rdata)
    );

    flt_ram #(.WIDTH(32), .DEPTH(ZDEPTH)) u_z_ram (
        .clk   (clk),
        .we    (z_we),
        .waddr (z_waddr),
        .wdata (z_wdata),
        .re    (state_reg == ST_UPD),
        .raddr (pass_zaddr),
        .rdata (z_rdata)
    );

    flt_ram #(.WIDTH(32), .DEPTH(DIM)) u_mean_ram (
        .clk   (clk),
        .we    (mean_we),
        .waddr (mean_waddr),
        .wdata (mean_wdata),
        .re    (mean_re),
        .raddr (mean_raddr),
        .rdata (mean_rdata)
    );

    // ------------------------------------------------------------------
    // Sigmoid lookup. The product y*dot is floored to Q8.24, clamped to
    // the table range and scaled to an index.
    // ------------------------------------------------------------------
    logic signed [39:0] u_c;
    logic [27:0]        uoff_c;
    logic [41:0]        scaled_c;
    logic [IW-1:0]      rom_addr;
    logic signed [31:0] rom_data;

    always_comb
    begin
        u_c      = 40'(uprod_reg >>> 24);
        uoff_c   = 28'(u_c + 40'sd134217728);
        scaled_c = 42'(uoff_c) * 42'(SIGMOID_ENTRIES);
        if (u_c < -40'sd134217728)
        begin
            rom_addr = '0;
        end
        else if (u_c >= 40'sd134217728)
        begin
            rom_addr = IW'(SIGMOID_ENTRIES - 1);
        end
        else
        begin
            rom_addr = IW'(scaled_c >> 28);
        end
    end

    flt_sig_rom #(.Entries(SIGMOID_ENTRIES)) u_sig_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    // ------------------------------------------------------------------
    // Update pipeline.
    // ------------------------------------------------------------------
    flt_update #(.ZA_W(ZA_W), .MA_W(MA_W)) u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (issue_d_reg),
        .in_zaddr   (za_d_reg),
        .in_maddr   (ma_d_reg),
        .x          (feat_rdata),
        .z          (z_rdata),
        .m          (mean_rdata),
        .gy         (gy_reg),
        .step_size  (step_size_reg),
        .reg_weight (reg_weight_reg),
        .inv_count  (inv_count_reg),
        .out_zaddr  (upd_zaddr),
        .out_maddr  (upd_maddr),
        .out_z      (upd_z),
        .out_m      (upd_m),
        .stat       (upd_stat)
    );

    // Rounding results used by the sequencer.
    sat_t dot_c;
    sat_t gy_c;

    always_comb
    begin
        dot_c = rnd_sat(WIDE_W'(acc_reg), 24);
        gy_c  = rnd_sat(WIDE_W'(gprod_reg), 24);
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            cnt_reg     <= '0;
            rd_ok_reg   <= 1'b0;
            sat_reg     <= 1'b0;
            dv1_reg     <= 1'b0;
            dv2_reg     <= 1'b0;
            issue_d_reg <= 1'b0;
            done_reg    <= 1'b0;
            kind_reg    <= RK_STEP;
            satout_reg  <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            dv1_reg     <= (state_reg == ST_DOT);
            dv2_reg     <= dv1_reg;
            issue_d_reg <= (state_reg == ST_UPD);
            if (upd_stat.sat)
            begin
                sat_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ZA_W'(ZDEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (action_t'(action))
                            ACT_READ_MEAN:
                            begin
                                rd_ok_reg <= col_ok;
                                state_reg <= ST_READ;
                            end
                            ACT_STEP:
                            begin
                                if (step_ok)
                                begin
                                    sat_reg   <= 1'b0;
                                    cnt_reg   <= '0;
                                    state_reg <= ST_DOT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ:
                begin
                    done_reg   <= 1'b1;
                    kind_reg   <= RK_MEAN;
                    satout_reg <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
                ST_DOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MA_W'(DIM - 1))
                    begin
                        state_reg <= ST_DOT_WAIT;
                    end
                end
                ST_DOT_WAIT:
                begin
                    if (!dv1_reg && !dv2_reg)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    if (dot_c.sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                    state_reg <= ST_UPROD;
                end
                ST_UPROD:    state_reg <= ST_INDEX;
                ST_INDEX:    state_reg <= ST_GPROD;
                ST_GPROD:    state_reg <= ST_GY;
                ST_GY:
                begin
                    if (gy_c.sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MA_W'(DIM - 1))
                    begin
                        state_reg <= ST_UPD_WAIT;
                    end
                end
                ST_UPD_WAIT:
                begin
                    // All columns are written back once the pipeline is empty.
                    if (!issue_d_reg && !upd_stat.busy)
                    begin
                        done_reg   <= 1'b1;
                        kind_reg   <= RK_STEP;
                        satout_reg <= sat_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(feat_rdata) * 64'(mean_rdata);
        if (accept)
        begin
            acc_reg  <= '0;
            base_reg <= ZA_W'(32'(sample) * 32'(DIM));
        end
        else if (dv2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_ROUND)
        begin
            dot_reg <= dot_c.val;
        end
        uprod_reg <= 64'(label_rdata) * 64'(dot_reg);
        gprod_reg <= 64'(rom_data) * 64'(label_rdata);
        if (state_reg == ST_GY)
        begin
            gy_reg <= gy_c.val;
        end
        za_d_reg <= pass_zaddr;
        ma_d_reg <= cnt_reg;
        if (state_reg == ST_READ)
        begin
            value_reg <= rd_ok_reg ? mean_rdata : 32'sd0;
        end
        else if (state_reg == ST_UPD_WAIT)
        begin
            value_reg <= dot_reg;
        end
    end

    assign done         = done_reg;
    assign result_kind  = kind_reg;
    assign result_value = value_reg;
    assign saturated    = satout_reg;

endmodule

/* rtl/flt_checker.sv */
// ============================================================================
// flt_checker
// Port-level checks on the command and result words of the trainer.
// ============================================================================
module flt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [flt_pkg::ACTION_W-1:0]  action,
    input logic                          done,
    input logic                          result_kind,
    input logic                          saturated
);
    import flt_pkg::*;

    // Each accepted mean read is followed by a mean result word.
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_READ_MEAN) |-> ##2 (done && result_kind == RK_MEAN))
        else $error("mean read word missing");

    // A mean read word never carries the saturation flag.
    a_read_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == RK_MEAN) |-> !saturated)
        else $error("mean read word flagged saturated");

    // Result words are never issued back to back.
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result words");

    // A step word closes a busy period.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind == RK_STEP) |-> $past(busy))
        else $error("step word without a preceding busy cycle");

endmodule

bind finito_logistic_trainer flt_checker u_flt_checker (.*);

/* tb/sv/flt_trainer_checker.sv */
// ============================================================================
// flt_trainer_checker
// Watches the command, result and register channels of the trainer, keeps
// its own fixed-point copy of the trainer state, and checks each result word.
// ============================================================================
module flt_trainer_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [flt_pkg::ACTION_W-1:0]  action,
    input  logic [flt_pkg::SAMPLE_W-1:0]  sample,
    input  logic [flt_pkg::FEATURE_W-1:0] feature,
    input  logic signed [31:0]            value,
    input  logic                          done,
    input  logic                          result_kind,
    input  logic signed [31:0]            result_value,
    input  logic                          saturated,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [flt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            steps_checked,
    output int                            reads_checked,
    output int                            sat_steps
);
    import flt_pkg::*;

    localparam int RING = 8;

    typedef struct {
        logic                kind;
        logic signed [31:0]  val;
        logic                sat;
    } outcome_t;

    // Expected words in order, held in a small ring.
    outcome_t ring[RING];
    int       wr_ptr;
    int       rd_ptr;
    int       fill;

    int sig_table[FLT_SIGMOID_ENTRIES];
    int feat_mem[FLT_NUM_SAMPLES*FLT_DIM];
    int label_mem[FLT_NUM_SAMPLES];
    int z_mem[FLT_NUM_SAMPLES*FLT_DIM];
    int mean_mem[FLT_DIM];

    logic [30:0] alpha;
    logic [30:0] lambda;
    logic [31:0] inv_n;

    task automatic enqueue(input outcome_t o);
        ring[wr_ptr] = o;
        wr_ptr = (wr_ptr + 1) % RING;
        fill++;
    endtask

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // exp(-a) in Q2.62 for an unsigned Q8.24 argument of at most 8.
    function automatic logic [63:0] exp_q62(input logic [63:0] a);
        logic [63:0] one;
        logic [63:0] r;
        logic [63:0] h;
        one = 64'd1 << 62;
        r = a << 30;
        h = one - r / 5;
        h = one - q62_mul(r, h) / 4;
        h = one - q62_mul(r, h) / 3;
        h = one - q62_mul(r, h) / 2;
        h = one - q62_mul(r, h);
        for (int k = 0; k < 8; k++)
            h = q62_mul(h, h);
        return h;
    endfunction

    function automatic int clip(input logic signed [79:0] v, inout bit flag);
        if (v > 80'sd2147483647)
        begin
            flag = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (v < -80'sd2147483648)
        begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // Exact product rounded half up at bit sh, then clipped to a word.
    function automatic int prod_round(input longint a, input longint b, input int sh,
                                      inout bit flag);
        longint p;
        p = a * b;
        return clip((p + (longint'(1) << (sh - 1))) >>> sh, flag);
    endfunction

    initial
    begin
        longint t;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] n32;
        logic [63:0] d32;
        logic [63:0] one;
        one = 64'd1 << 62;
        for (int i = 0; i < FLT_SIGMOID_ENTRIES; i++)
        begin
            t = -(longint'(1) << 27)
                + longint'((longint'(2 * i + 1) << 27) / FLT_SIGMOID_ENTRIES);
            e = exp_q62(t < 0 ? -t : t);
            num = (t >= 0) ? e : one;
            n32 = num >> 30;
            d32 = (one + e) >> 30;
            sig_table[i] = -int'(((n32 << 24) + d32 / 2) / d32);
        end
    end

    // One train step: the dot product, the sigmoid lookup and the update of
    // both the sample's stored vector and the mean.
    task automatic run_step(input int s);
        logic signed [79:0] acc;
        longint pr;
        longint y;
        longint u;
        int base;
        int idx;
        int dot;
        int gy;
        int m;
        int t1;
        int t2;
        int grad;
        int stp;
        int d;
        int dl;
        int inc;
        bit flag;
        outcome_t o;
        flag = 1'b0;
        base = s * FLT_DIM;
        acc = '0;
        for (int c = 0; c < FLT_DIM; c++)
        begin
            pr = longint'(mean_mem[c]) * longint'(feat_mem[base + c]);
            acc = acc + pr;
        end
        dot = clip((acc + (80'sd1 <<< 23)) >>> 24, flag);
        y = label_mem[s];
        u = (y * longint'(dot)) >>> 24;
        if (u < -(longint'(1) << 27))
            idx = 0;
        else if (u >= (longint'(1) << 27))
            idx = FLT_SIGMOID_ENTRIES - 1;
        else
            idx = int'(((u + (longint'(1) << 27)) * FLT_SIGMOID_ENTRIES) >>> 28);
        gy = prod_round(sig_table[idx], y, 24, flag);
        for (int c = 0; c < FLT_DIM; c++)
        begin
            m = mean_mem[c];
            t1 = prod_round(gy, feat_mem[base + c], 24, flag);
            t2 = prod_round(longint'(lambda), m, 24, flag);
            grad = clip(longint'(t1) + longint'(t2), flag);
            stp = prod_round(longint'(alpha), grad, 24, flag);
            d = clip(longint'(m) - longint'(z_mem[base + c]), flag);
            dl = clip(longint'(d) - longint'(stp), flag);
            inc = prod_round(dl, longint'(inv_n), 32, flag);
            z_mem[base + c] = clip(longint'(z_mem[base + c]) + longint'(dl), flag);
            mean_mem[c] = clip(longint'(m) + longint'(inc), flag);
        end
        o.kind = RK_STEP;
        o.val = dot;
        o.sat = flag;
        enqueue(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t want;
        if (!rst_n)
        begin
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
            for (int i = 0; i < FLT_NUM_SAMPLES * FLT_DIM; i++)
                z_mem[i] = 0;
            for (int i = 0; i < FLT_DIM; i++)
                mean_mem[i] = 0;
            alpha = STEP_SIZE_RESET;
            lambda = REG_WEIGHT_RESET;
            inv_n = INV_COUNT_RESET;
            errors = 0;
            steps_checked = 0;
            reads_checked = 0;
            sat_steps = 0;
        end
        else
        begin
            // Results are compared before the new command is applied, so a
            // word leaving the block is never checked against later state.
            if (done)
            begin
                if (fill == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: result word kind=%0d value=%0d with none expected",
                                 result_kind, result_value);
                end
                else
                begin
                    want = ring[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % RING;
                    fill--;
                    if (result_kind !== want.kind || result_value !== want.val
                        || saturated !== want.sat)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: expected kind=%0d value=%0d sat=%0d, got %0d %0d %0d",
                                     want.kind, want.val, want.sat,
                                     result_kind, result_value, saturated);
                    end
                    if (want.kind == RK_STEP)
                    begin
                        steps_checked++;
                        if (want.sat)
                            sat_steps++;
                    end
                    else
                        reads_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_STEP_SIZE:  alpha = cfg_data[30:0];
                    CFG_REG_WEIGHT: lambda = cfg_data[30:0];
                    CFG_INV_COUNT:  inv_n = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (action_t'(action))
                    ACT_LOAD_FEATURE: feat_mem[sample * FLT_DIM + feature] = value;
                    ACT_LOAD_LABEL:   label_mem[sample] = value;
                    ACT_READ_MEAN:
                    begin
                        o.kind = RK_MEAN;
                        o.val = mean_mem[feature];
                        o.sat = 1'b0;
                        enqueue(o);
                    end
                    default: run_step(sample);
                endcase
            end
        end
        pending = fill;
    end

endmodule

/* tb/sv/tb_finito_logistic_trainer.sv */
// ============================================================================
// tb_finito_logistic_trainer
// Drives loads, train steps, mean reads and register writes into the trainer
// with bursty timing; a checker module beside the block verifies each word.
// ============================================================================
module tb_finito_logistic_trainer;
    import flt_pkg::*;

    localparam int POOL = 5;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ACTION_W-1:0]  action;
    logic [SAMPLE_W-1:0]  sample;
    logic [FEATURE_W-1:0] feature;
    logic signed [31:0]   value;
    logic                 done;
    logic                 result_kind;
    logic signed [31:0]   result_value;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    int errors;
    int pending;
    int steps_checked;
    int reads_checked;
    int sat_steps;

    // Samples whose whole feature row and label are written; only these are
    // ever trained, so no step reads a store entry that was never written.
    int pool[POOL];
    int burst_left;
    int words_sent;

    finito_logistic_trainer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .sample       (sample),
        .feature      (feature),
        .value        (value),
        .done         (done),
        .result_kind  (result_kind),
        .result_value (result_value),
        .saturated    (saturated),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    flt_trainer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .sample        (sample),
        .feature       (feature),
        .value         (value),
        .done          (done),
        .result_kind   (result_kind),
        .result_value  (result_value),
        .saturated     (saturated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .steps_checked (steps_checked),
        .reads_checked (reads_checked),
        .sat_steps     (sat_steps)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = ~clk;
    end

    // Watchdog. The slowest correct run is the reset clearing pass plus about
    // 700 words at a full step and the longest sender gap each, well under a
    // quarter of this limit.
    initial
    begin
        #8000000;
        $display("*** FAILED ***");
        $finish;
    end

    // A random Q8.24 word: mostly small values near the useful range, with
    // full-range words and the two extremes mixed in.
    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        if (r < 75)
            return $urandom;
        if (r < 85)
            return 32'sh7FFF_FFFF;
        if (r < 92)
            return 32'sh8000_0000;
        return ($urandom_range(0, 1) != 0) ? 32'sh0100_0000 : -32'sh0100_0000;
    endfunction

    // Sends one command word. Words go out in bursts; between bursts start
    // drops for a random gap, sometimes long, so gaps land on every phase of
    // a step. Inputs change only on the falling edge.
    task automatic send_word(input action_t a, input int s, input int f,
                             input logic signed [31:0] v);
        @(negedge clk);
        if (burst_left == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 160)
                                              : $urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 14);
        end
        burst_left--;
        start = 1'b1;
        action = a;
        sample = SAMPLE_W'(s);
        feature = FEATURE_W'(f);
        value = v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (burst_left == 0)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    task automatic fill_row(input int s);
        for (int c = 0; c < FLT_DIM; c++)
            send_word(ACT_LOAD_FEATURE, s, c, pick_value());
        send_word(ACT_LOAD_LABEL, s, 0, ($urandom_range(0, 1) != 0) ? 32'sh0100_0000
                                                                    : -32'sh0100_0000);
    endtask

    // Registers change only with the block idle: all words back, busy low,
    // and a margin for a step pipeline that may still be draining.
    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (30) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_words(input int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
                send_word(ACT_STEP, pool[$urandom_range(0, POOL - 1)], $urandom_range(0, 63),
                          $urandom);
            else if (r < 55)
                send_word(ACT_READ_MEAN, $urandom_range(0, 1023), $urandom_range(0, 63),
                          $urandom);
            else if (r < 80)
                send_word(ACT_LOAD_FEATURE, pool[$urandom_range(0, POOL - 1)],
                          $urandom_range(0, 63), pick_value());
            else if (r < 90)
                send_word(ACT_LOAD_LABEL, pool[$urandom_range(0, POOL - 1)],
                          $urandom_range(0, 63), pick_value());
            else
                // Loads to rows outside the pool: harmless, never trained.
                send_word(($urandom_range(0, 1) != 0) ? ACT_LOAD_FEATURE : ACT_LOAD_LABEL,
                          $urandom_range(0, 1023), $urandom_range(0, 63), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_LOAD_FEATURE;
        sample = '0;
        feature = '0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP_SIZE;
        cfg_data = '0;
        burst_left = 0;
        words_sent = 0;
        pool[0] = 0;
        pool[1] = 1023;
        for (int i = 2; i < POOL; i++)
            pool[i] = $urandom_range(1, 1022);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reads of the cleared mean at both ends, rows with
        // the extreme feature words, labels of both signs, a step at each end
        // of the sample range, and a read of every column edge afterwards.
        send_word(ACT_READ_MEAN, 0, 0, 0);
        send_word(ACT_READ_MEAN, 1023, 63, 0);
        for (int i = 0; i < POOL; i++)
            fill_row(pool[i]);
        send_word(ACT_LOAD_FEATURE, 0, 0, 32'sh7FFF_FFFF);
        send_word(ACT_LOAD_FEATURE, 0, 63, 32'sh8000_0000);
        send_word(ACT_LOAD_LABEL, 1023, 0, 32'sh7FFF_FFFF);
        send_word(ACT_STEP, 0, 0, 0);
        send_word(ACT_STEP, 1023, 0, 0);
        send_word(ACT_STEP, 0, 0, 0);
        send_word(ACT_LOAD_LABEL, 1023, 0, 32'sh8000_0000);
        send_word(ACT_STEP, 1023, 0, 0);
        send_word(ACT_READ_MEAN, 0, 0, 0);
        send_word(ACT_READ_MEAN, 0, 63, 0);

        // Reset register values first, then all at maximum, all at zero, and
        // finally a moderate setting.
        random_words(90);
        write_reg(CFG_STEP_SIZE, 32'h7FFF_FFFF);
        write_reg(CFG_REG_WEIGHT, 32'h7FFF_FFFF);
        write_reg(CFG_INV_COUNT, 32'hFFFF_FFFF);
        random_words(80);
        write_reg(CFG_STEP_SIZE, 32'h0);
        write_reg(CFG_REG_WEIGHT, 32'h0);
        write_reg(CFG_INV_COUNT, 32'h0);
        random_words(70);
        write_reg(CFG_STEP_SIZE, 32'h0040_0000);
        write_reg(CFG_REG_WEIGHT, 32'h0001_0000);
        write_reg(CFG_INV_COUNT, 32'h0800_0000);
        random_words(110);

        @(negedge clk);
        start = 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Run covered %0d command words: %0d train steps (%0d with saturation)",
                 words_sent, steps_checked, sat_steps);
        $display("and %0d mean reads over four register settings.", reads_checked);
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
